### hw/rtl/pob_pkg.sv
// Shared types, constants and mode codes for the pixel overlay blend pipeline.
package pob_pkg;

    localparam int PIX_W          = 16;
    localparam int LANES          = 3;
    localparam int DEPTH_W        = 5;
    localparam int OPAC_W         = 9;
    localparam int MODE_W         = 3;
    localparam int INDEX_W        = 2;
    localparam int DATA_W         = 9;
    localparam int DIFF_W         = PIX_W + 1;
    localparam int MW_W           = PIX_W + OPAC_W;
    localparam int PROD_W         = 2 * DIFF_W;
    localparam int SUM_W          = PROD_W + 1;

    localparam logic [DEPTH_W-1:0] MIN_PIXEL_BITS = DEPTH_W'(8);
    localparam logic [DEPTH_W-1:0] MAX_PIXEL_BITS = DEPTH_W'(16);
    localparam logic [DEPTH_W-1:0] OPACITY_BITS   = DEPTH_W'(8);
    localparam logic [OPAC_W-1:0]  OPACITY_FULL   = OPAC_W'(256);

    localparam logic [MODE_W-1:0] MODE_MASKED    = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_OPACITY   = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MASK_OPAC = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_DARKEN    = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_LIGHTEN   = MODE_W'(4);

    localparam logic [INDEX_W-1:0] REG_BLEND_MODE = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] REG_BIT_DEPTH  = INDEX_W'(1);
    localparam logic [INDEX_W-1:0] REG_OPACITY    = INDEX_W'(2);

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [1:0] {
        SEL_BASE,
        SEL_OVER,
        SEL_MIX
    } sel_t;

    typedef struct packed {
        logic [MODE_W-1:0]            mode;
        logic [DEPTH_W-1:0]           sh;
        logic [OPAC_W-1:0]            op;
        sel_t [LANES-1:0]             sel;
        pix_t [LANES-1:0]             p1;
        pix_t [LANES-1:0]             p2;
        pix_t [LANES-1:0]             m;
        logic [LANES-1:0][DIFF_W-1:0] d;
        logic [LANES-1:0][MW_W-1:0]   mw;
    } prep_t;

    typedef struct packed {
        logic [DEPTH_W-1:0]           sh;
        sel_t [LANES-1:0]             sel;
        pix_t [LANES-1:0]             p1;
        pix_t [LANES-1:0]             p2;
        logic [LANES-1:0][PROD_W-1:0] prod;
    } mul_t;

endpackage

### hw/rtl/pob_prep.sv
// First stage: depth clamp, sample truncation, differences, mask scaling and selection.
module pob_prep
    import pob_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [MODE_W-1:0]  blend_mode,
    input  logic [DEPTH_W-1:0] bit_depth,
    input  logic [OPAC_W-1:0]  opacity,
    input  pix_t [LANES-1:0]   base,
    input  pix_t [LANES-1:0]   over,
    input  pix_t [LANES-1:0]   mask,
    output logic               s1_valid,
    output prep_t              s1
);

    logic [DEPTH_W-1:0] eff;
    pix_t               pmask;
    logic [OPAC_W-1:0]  op_sat;
    logic               take;
    prep_t              s1_next;
    prep_t              s1_reg;
    logic               s1_valid_reg;

    always_comb
    begin
        eff = bit_depth;
        if (bit_depth < MIN_PIXEL_BITS)
        begin
            eff = MIN_PIXEL_BITS;
        end
        else if (bit_depth > MAX_PIXEL_BITS)
        begin
            eff = MAX_PIXEL_BITS;
        end
        pmask  = PIX_W'((DIFF_W'(1) << eff) - DIFF_W'(1));
        op_sat = (opacity > OPACITY_FULL) ? OPACITY_FULL : opacity;

        s1_next.mode = blend_mode;
        s1_next.sh   = (blend_mode == MODE_OPACITY) ? OPACITY_BITS : eff;
        s1_next.op   = op_sat;
        for (int i = 0; i < LANES; i++)
        begin
            s1_next.p1[i] = base[i] & pmask;
            s1_next.p2[i] = over[i] & pmask;
            s1_next.m[i]  = mask[i] & pmask;
            s1_next.d[i]  = {1'b0, s1_next.p2[i]} - {1'b0, s1_next.p1[i]};
            s1_next.mw[i] = MW_W'(s1_next.m[i]) * MW_W'(op_sat);
        end

        if (blend_mode == MODE_DARKEN)
        begin
            take = (s1_next.p2[0] <= s1_next.p1[0]);
        end
        else
        begin
            take = (s1_next.p2[0] >= s1_next.p1[0]);
        end

        for (int i = 0; i < LANES; i++)
        begin
            unique case (blend_mode) inside
                MODE_MASKED:
                begin
                    if (s1_next.m[i] == '0)
                    begin
                        s1_next.sel[i] = SEL_BASE;
                    end
                    else if (s1_next.m[i] == pmask)
                    begin
                        s1_next.sel[i] = SEL_OVER;
                    end
                    else
                    begin
                        s1_next.sel[i] = SEL_MIX;
                    end
                end
                MODE_OPACITY, MODE_MASK_OPAC:
                begin
                    s1_next.sel[i] = SEL_MIX;
                end
                MODE_DARKEN, MODE_LIGHTEN:
                begin
                    s1_next.sel[i] = take ? SEL_OVER : SEL_BASE;
                end
                default:
                begin
                    s1_next.sel[i] = SEL_BASE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

### hw/rtl/pob_weight.sv
// Second stage: weight selection and signed difference-times-weight multiply.
module pob_weight
    import pob_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s1_valid,
    input  prep_t s1,
    output logic  s2_valid,
    output mul_t  s2
);

    pix_t [LANES-1:0] w;
    mul_t             s2_next;
    mul_t             s2_reg;
    logic             s2_valid_reg;

    always_comb
    begin
        s2_next.sh  = s1.sh;
        s2_next.sel = s1.sel;
        s2_next.p1  = s1.p1;
        s2_next.p2  = s1.p2;
        for (int i = 0; i < LANES; i++)
        begin
            case (s1.mode)
                MODE_MASK_OPAC:
                begin
                    w[i] = s1.mw[i][PIX_W+OPACITY_BITS-1:OPACITY_BITS];
                end
                MODE_OPACITY:
                begin
                    w[i] = PIX_W'(s1.op);
                end
                default:
                begin
                    w[i] = s1.m[i];
                end
            endcase
            s2_next.prod[i] = $signed({{(PROD_W-DIFF_W){s1.d[i][DIFF_W-1]}}, s1.d[i]})
                            * $signed({{(PROD_W-PIX_W){1'b0}}, w[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

### hw/rtl/pob_mix.sv
// Third stage: rounding, scale shift, base add and final sample selection.
module pob_mix
    import pob_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s2_valid,
    input  mul_t             s2,
    output logic             done,
    output pix_t [LANES-1:0] result
);

    logic [SUM_W-1:0]               half;
    logic signed [LANES-1:0][SUM_W-1:0] sum;
    logic signed [LANES-1:0][SUM_W-1:0] q;
    pix_t [LANES-1:0]               result_next;
    pix_t [LANES-1:0]               result_reg;
    logic                           done_reg;

    always_comb
    begin
        half = SUM_W'(1) << (s2.sh - DEPTH_W'(1));
        for (int i = 0; i < LANES; i++)
        begin
            sum[i] = $signed({s2.prod[i][PROD_W-1], s2.prod[i]}) + $signed(half);
            q[i]   = $signed(sum[i]) >>> s2.sh;
            case (s2.sel[i])
                SEL_OVER:
                begin
                    result_next[i] = s2.p2[i];
                end
                SEL_MIX:
                begin
                    result_next[i] = s2.p1[i] + q[i][PIX_W-1:0];
                end
                default:
                begin
                    result_next[i] = s2.p1[i];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### hw/rtl/pixel_overlay_blend_top.sv
// Top level of the pixel overlay blend: register file and three-stage blend pipeline.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------------
//   request   | start / busy       | base_y/u/v, over_y/u/v, mask_y/u/v
//   result    | done (one cycle)   | out_y, out_u, out_v
//   config    | wr_en              | wr_index, wr_data
//
// One request per clock; busy stays low. Each result is registered in turn by the
// prepare, multiply and mix register stages.
// Reset clears the stage valid bits and loads mode 0, depth 8, opacity 256.
// The pipeline never stalls; results must be taken in the cycle done is high.
module pixel_overlay_blend_top
    import pob_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  pix_t               base_y,
    input  pix_t               base_u,
    input  pix_t               base_v,
    input  pix_t               over_y,
    input  pix_t               over_u,
    input  pix_t               over_v,
    input  pix_t               mask_y,
    input  pix_t               mask_u,
    input  pix_t               mask_v,
    output logic               done,
    output pix_t               out_y,
    output pix_t               out_u,
    output pix_t               out_v,
    input  logic               wr_en,
    input  logic [INDEX_W-1:0] wr_index,
    input  logic [DATA_W-1:0]  wr_data
);

    logic [MODE_W-1:0]  blend_mode_reg;
    logic [DEPTH_W-1:0] bit_depth_reg;
    logic [OPAC_W-1:0]  opacity_reg;
    logic               accept;
    logic               s1_valid;
    logic               s2_valid;
    prep_t              s1;
    mul_t               s2;
    pix_t [LANES-1:0]   result;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg <= MODE_MASKED;
            bit_depth_reg  <= MIN_PIXEL_BITS;
            opacity_reg    <= OPACITY_FULL;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BLEND_MODE: blend_mode_reg <= wr_data[MODE_W-1:0];
                REG_BIT_DEPTH:  bit_depth_reg  <= wr_data[DEPTH_W-1:0];
                REG_OPACITY:    opacity_reg    <= wr_data[OPAC_W-1:0];
                default:        ;
            endcase
        end
    end

    pob_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .blend_mode (blend_mode_reg),
        .bit_depth  (bit_depth_reg),
        .opacity    (opacity_reg),
        .base       ({base_v, base_u, base_y}),
        .over       ({over_v, over_u, over_y}),
        .mask       ({mask_v, mask_u, mask_y}),
        .s1_valid   (s1_valid),
        .s1         (s1)
    );

    pob_weight u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1       (s1),
        .s2_valid (s2_valid),
        .s2       (s2)
    );

    pob_mix u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2_valid (s2_valid),
        .s2       (s2),
        .done     (done),
        .result   (result)
    );

    assign out_y = result[0];
    assign out_u = result[1];
    assign out_v = result[2];

`ifndef ASSERT_OFF
    a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##3 done)
        else $error("request did not produce a result three cycles later");

    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 3))
        else $error("result without a matching request");

    a_stage_valid_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid |-> $past(s1_valid))
        else $error("multiply stage valid without prepare stage valid");
`endif

endmodule

### tb/pixel_overlay_blend_top_tb.sv
// Self-checking testbench for pixel_overlay_blend_top: directed and random pixels vs a blend predictor.
`timescale 1ns / 100ps

module pixel_overlay_blend_top_tb;
    import pob_pkg::*;

    localparam int                 CYCLE_LIMIT   = 400000;
    localparam logic [INDEX_W-1:0] REG_UNUSED    = INDEX_W'(3);
    localparam logic [MODE_W-1:0]  MODE_UNDEF_LO = MODE_W'(5);
    localparam logic [MODE_W-1:0]  MODE_UNDEF_HI = MODE_W'(7);

    typedef pix_t [LANES-1:0] lanes_t;

    typedef struct packed {
        lanes_t base;
        lanes_t over;
        lanes_t mask;
    } pixel_req_t;

    class blend_scoreboard;
        logic [MODE_W-1:0]  mode;
        logic [DEPTH_W-1:0] depth;
        logic [OPAC_W-1:0]  opac;
        lanes_t             merged_q[$];
        int                 errors;
        int                 results;

        function new();
            mode    = MODE_MASKED;
            depth   = MIN_PIXEL_BITS;
            opac    = OPACITY_FULL;
            errors  = 0;
            results = 0;
        endfunction

        function int eff_bits();
            if (depth < MIN_PIXEL_BITS)
                return int'(MIN_PIXEL_BITS);
            if (depth > MAX_PIXEL_BITS)
                return int'(MAX_PIXEL_BITS);
            return int'(depth);
        endfunction

        function void write_reg(logic [INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_BLEND_MODE: mode  = data[MODE_W-1:0];
                REG_BIT_DEPTH:  depth = data[DEPTH_W-1:0];
                REG_OPACITY:    opac  = data[OPAC_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned weighted_mix(longint unsigned a, longint unsigned c,
                                               longint unsigned w, int sh);
            longint unsigned full;
            longint unsigned half;
            full = 64'd1 << sh;
            half = 64'd1 << (sh - 1);
            return (a * (full - w) + c * w + half) >> sh;
        endfunction

        function void note_request(pixel_req_t px);
            int              b;
            int              lane;
            longint unsigned pmask;
            longint unsigned op;
            longint unsigned p1;
            longint unsigned p2;
            longint unsigned m;
            longint unsigned val;
            logic            take;
            lanes_t          merged;
            b     = eff_bits();
            pmask = (64'd1 << b) - 64'd1;
            op    = (opac > OPACITY_FULL) ? OPACITY_FULL : opac;
            if (mode == MODE_DARKEN)
                take = (px.over[0] & pmask) <= (px.base[0] & pmask);
            else
                take = (px.over[0] & pmask) >= (px.base[0] & pmask);
            for (lane = 0; lane < LANES; lane++)
            begin
                p1 = px.base[lane] & pmask;
                p2 = px.over[lane] & pmask;
                m  = px.mask[lane] & pmask;
                case (mode)
                    MODE_MASKED:
                    begin
                        if (m == 0)
                            val = p1;
                        else if (m >= pmask)
                            val = p2;
                        else
                            val = weighted_mix(p1, p2, m, b);
                    end
                    MODE_OPACITY:   val = weighted_mix(p1, p2, op, int'(OPACITY_BITS));
                    MODE_MASK_OPAC: val = weighted_mix(p1, p2, (m * op) >> OPACITY_BITS, b);
                    MODE_DARKEN,
                    MODE_LIGHTEN:   val = take ? p2 : p1;
                    default:        val = p1;
                endcase
                merged[lane] = pix_t'(val & pmask);
            end
            merged_q.push_back(merged);
        endfunction

        function string lane_name(int lane);
            case (lane)
                0:       return "out_y";
                1:       return "out_u";
                default: return "out_v";
            endcase
        endfunction

        function void check_result(lanes_t got);
            lanes_t want;
            int     lane;
            results++;
            if (merged_q.size() == 0)
            begin
                $error("unexpected result out_y=%0h out_u=%0h out_v=%0h",
                       got[0], got[1], got[2]);
                errors++;
                return;
            end
            want = merged_q.pop_front();
            for (lane = 0; lane < LANES; lane++)
            begin
                if (got[lane] !== want[lane])
                begin
                    $error("%s: expected %0h, actual %0h", lane_name(lane), want[lane], got[lane]);
                    errors++;
                end
            end
        endfunction

        function void report_leftover();
            if (merged_q.size() != 0)
            begin
                $error("%0d expected results never arrived", merged_q.size());
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    pix_t               base_y;
    pix_t               base_u;
    pix_t               base_v;
    pix_t               over_y;
    pix_t               over_u;
    pix_t               over_v;
    pix_t               mask_y;
    pix_t               mask_u;
    pix_t               mask_v;
    logic               done;
    pix_t               out_y;
    pix_t               out_u;
    pix_t               out_v;
    logic               wr_en;
    logic [INDEX_W-1:0] wr_index;
    logic [DATA_W-1:0]  wr_data;

    blend_scoreboard sb;
    int              sent_count = 0;
    int              cycle_count = 0;

    pixel_overlay_blend_top dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (wr_en)
                sb.write_reg(wr_index, wr_data);
            if (start && !busy)
                sb.note_request('{base: '{base_v, base_u, base_y},
                                  over: '{over_v, over_u, over_y},
                                  mask: '{mask_v, mask_u, mask_y}});
            if (done)
                sb.check_result('{out_v, out_u, out_y});
        end
    end

    function automatic pixel_req_t make_px(pix_t by, pix_t bu, pix_t bv,
                                           pix_t oy, pix_t ou, pix_t ov,
                                           pix_t my, pix_t mu, pix_t mv);
        pixel_req_t px;
        px.base = '{bv, bu, by};
        px.over = '{ov, ou, oy};
        px.mask = '{mv, mu, my};
        return px;
    endfunction

    function automatic pix_t pick_sample(pix_t pmask);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return pmask;
            2:       return 16'hFFFF;
            3:       return pix_t'($urandom) & pmask;
            default: return pix_t'($urandom);
        endcase
    endfunction

    function automatic pix_t pick_mask(pix_t pmask);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return pmask;
            2:       return 16'd1;
            3:       return pmask - 16'd1;
            4:       return pmask + 16'd1;
            5:       return pix_t'($urandom);
            default: return pix_t'($urandom) & pmask;
        endcase
    endfunction

    function automatic pixel_req_t random_px();
        pixel_req_t px;
        pix_t       pmask;
        int         lane;
        pmask = pix_t'((32'd1 << sb.eff_bits()) - 1);
        for (lane = 0; lane < LANES; lane++)
        begin
            px.base[lane] = pick_sample(pmask);
            px.over[lane] = pick_sample(pmask);
            px.mask[lane] = pick_mask(pmask);
        end
        if ((sb.mode == MODE_DARKEN || sb.mode == MODE_LIGHTEN) && $urandom_range(0, 3) == 0)
            px.over[0] = px.base[0] ^ (pix_t'($urandom) & ~pmask);
        return px;
    endfunction

    task automatic drive_px(input pixel_req_t px);
        start  <= 1'b1;
        base_y <= px.base[0];
        base_u <= px.base[1];
        base_v <= px.base[2];
        over_y <= px.over[0];
        over_u <= px.over[1];
        over_v <= px.over[2];
        mask_y <= px.mask[0];
        mask_u <= px.mask[1];
        mask_v <= px.mask[2];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic wait_drain();
        while (sb.results < sent_count)
            @(posedge clk);
    endtask

    task automatic apply_config(input logic [MODE_W-1:0] mode, input logic [DEPTH_W-1:0] depth,
                                input logic [OPAC_W-1:0] op);
        logic [DATA_W-1:0] noise;
        noise = DATA_W'($urandom);
        wait_drain();
        wr_en    <= 1'b1;
        wr_index <= REG_BLEND_MODE;
        wr_data  <= {noise[DATA_W-1:MODE_W], mode};
        @(posedge clk);
        wr_index <= REG_BIT_DEPTH;
        wr_data  <= {noise[DATA_W-1:DEPTH_W], depth};
        @(posedge clk);
        wr_index <= REG_OPACITY;
        wr_data  <= op;
        @(posedge clk);
        wr_index <= REG_UNUSED;
        wr_data  <= DATA_W'($urandom);
        @(posedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic run_pixels(input int count, input bit idle_ok);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (idle_ok && $urandom_range(0, 99) < 11)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            drive_px(random_px());
        end
        start <= 1'b0;
    endtask

    task automatic run_directed();
        drive_px(make_px(16'h0012, 16'h0034, 16'h0056, 16'h00AB, 16'h00CD, 16'h00EF,
                         16'h0000, 16'h0000, 16'h0000));
        drive_px(make_px(16'h0012, 16'h0034, 16'h0056, 16'h00AB, 16'h00CD, 16'h00EF,
                         16'h00FF, 16'h01FF, 16'hFFFF));
        drive_px(make_px(16'h0000, 16'h0000, 16'h0000, 16'h00FF, 16'h00FF, 16'h00FF,
                         16'h0080, 16'h0001, 16'h00FE));
        drive_px(make_px(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                         16'h0100, 16'h007F, 16'h0080));
        start <= 1'b0;
        apply_config(MODE_MASKED, 5'd16, OPACITY_FULL);
        drive_px(make_px(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'h8000, 16'hFFFF, 16'h0001));
        drive_px(make_px(16'hFFFF, 16'h0000, 16'h1234, 16'h0000, 16'hFFFF, 16'hFEDC,
                         16'hFFFE, 16'h0000, 16'h7FFF));
        start <= 1'b0;
        apply_config(MODE_OPACITY, 5'd8, 9'd0);
        drive_px(make_px(16'h0012, 16'h00FF, 16'h0080, 16'h00FF, 16'h0000, 16'h007F,
                         16'h1234, 16'h5678, 16'h9ABC));
        start <= 1'b0;
        apply_config(MODE_OPACITY, 5'd16, OPACITY_FULL);
        drive_px(make_px(16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF,
                         16'h0000, 16'hFFFF, 16'h0001));
        start <= 1'b0;
        apply_config(MODE_OPACITY, 5'd10, 9'd511);
        drive_px(make_px(16'h0000, 16'h03FF, 16'hFC01, 16'h03FF, 16'h0000, 16'h0123,
                         16'h0000, 16'h0000, 16'h0000));
        start <= 1'b0;
        apply_config(MODE_OPACITY, 5'd12, 9'd128);
        drive_px(make_px(16'h0000, 16'h0FFF, 16'h0001, 16'h0001, 16'h0000, 16'h0002,
                         16'h0FFF, 16'h0000, 16'h0800));
        start <= 1'b0;
        apply_config(MODE_MASK_OPAC, 5'd12, OPACITY_FULL);
        drive_px(make_px(16'h0000, 16'h0FFF, 16'h0123, 16'h0FFF, 16'h0000, 16'h0ABC,
                         16'h0FFF, 16'h0000, 16'h0800));
        start <= 1'b0;
        apply_config(MODE_MASK_OPAC, 5'd14, 9'd0);
        drive_px(make_px(16'h3FFF, 16'h0000, 16'h1234, 16'h0000, 16'h3FFF, 16'h2345,
                         16'h3FFF, 16'h1FFF, 16'hFFFF));
        start <= 1'b0;
        apply_config(MODE_MASK_OPAC, 5'd8, 9'd300);
        drive_px(make_px(16'h0000, 16'h00FF, 16'h0040, 16'h00FF, 16'h0000, 16'h00C0,
                         16'h00FF, 16'h0080, 16'h0001));
        start <= 1'b0;
        apply_config(MODE_DARKEN, 5'd10, OPACITY_FULL);
        drive_px(make_px(16'h0155, 16'h0011, 16'h0022, 16'hFD55, 16'h0333, 16'h0344,
                         16'h0000, 16'h0000, 16'h0000));
        drive_px(make_px(16'h0200, 16'h0011, 16'h0022, 16'h01FF, 16'h0333, 16'h0344,
                         16'hFFFF, 16'hFFFF, 16'hFFFF));
        drive_px(make_px(16'h0200, 16'h0011, 16'h0022, 16'h0201, 16'h0333, 16'h0344,
                         16'h0000, 16'h0000, 16'h0000));
        start <= 1'b0;
        apply_config(MODE_LIGHTEN, 5'd16, OPACITY_FULL);
        drive_px(make_px(16'hABCD, 16'h0011, 16'h0022, 16'hABCD, 16'hEEEE, 16'hDDDD,
                         16'h0000, 16'h0000, 16'h0000));
        drive_px(make_px(16'hFFFF, 16'h0011, 16'h0022, 16'h0000, 16'hEEEE, 16'hDDDD,
                         16'h0000, 16'h0000, 16'h0000));
        drive_px(make_px(16'h0000, 16'h0011, 16'h0022, 16'hFFFF, 16'hEEEE, 16'hDDDD,
                         16'h0000, 16'h0000, 16'h0000));
        start <= 1'b0;
        apply_config(MODE_UNDEF_LO, 5'd8, OPACITY_FULL);
        drive_px(make_px(16'hF012, 16'h0034, 16'h0056, 16'h00AB, 16'h00CD, 16'h00EF,
                         16'h0080, 16'h0080, 16'h0080));
        start <= 1'b0;
        apply_config(MODE_UNDEF_HI, 5'd16, 9'd64);
        drive_px(make_px(16'hF012, 16'h0034, 16'h0056, 16'h00AB, 16'h00CD, 16'h00EF,
                         16'h0080, 16'h0080, 16'h0080));
        start <= 1'b0;
        apply_config(MODE_MASKED, 5'd0, OPACITY_FULL);
        drive_px(make_px(16'h1200, 16'hFF00, 16'h0000, 16'h34FF, 16'h0000, 16'h00FF,
                         16'h0180, 16'h00FF, 16'h7F7F));
        start <= 1'b0;
        apply_config(MODE_MASKED, 5'd31, OPACITY_FULL);
        drive_px(make_px(16'h1200, 16'hFF00, 16'h0000, 16'h34FF, 16'h0000, 16'hFFFF,
                         16'h0180, 16'hFFFF, 16'h7F7F));
        start <= 1'b0;
    endtask

    initial
    begin
        logic [MODE_W-1:0]  mode;
        logic [DEPTH_W-1:0] depth;
        logic [OPAC_W-1:0]  op;
        int                 phase;
        sb       = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        base_y   = '0;
        base_u   = '0;
        base_v   = '0;
        over_y   = '0;
        over_u   = '0;
        over_v   = '0;
        mask_y   = '0;
        mask_u   = '0;
        mask_v   = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (phase = 0; phase < 8; phase++)
        begin
            if ($urandom_range(0, 9) == 0)
                mode = MODE_W'($urandom_range(int'(MODE_UNDEF_LO), int'(MODE_UNDEF_HI)));
            else
                mode = MODE_W'($urandom_range(int'(MODE_MASKED), int'(MODE_LIGHTEN)));
            if ($urandom_range(0, 5) == 0)
                depth = DEPTH_W'($urandom_range(0, 31));
            else
                depth = DEPTH_W'(8 + 2 * $urandom_range(0, 4));
            case ($urandom_range(0, 4))
                0:       op = '0;
                1:       op = OPACITY_FULL;
                2:       op = OPAC_W'($urandom_range(257, 511));
                default: op = OPAC_W'($urandom_range(0, 256));
            endcase
            apply_config(mode, depth, op);
            run_pixels(150, phase != 3);
        end

        wait_drain();
        repeat (8)
            @(posedge clk);
        sb.report_leftover();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
hw/rtl/pob_pkg.sv
hw/rtl/pob_prep.sv
hw/rtl/pob_weight.sv
hw/rtl/pob_mix.sv
hw/rtl/pixel_overlay_blend_top.sv
tb/pixel_overlay_blend_top_tb.sv
